// File: sv/fixed_step_body_integrator_unit_defines.svh
// ----------------------------------------------------------------------------
// fixed step body integrator assertion macros
// shared assertion helpers for the integrator rtl
// ----------------------------------------------------------------------------
`ifndef FIXED_STEP_BODY_INTEGRATOR_UNIT_DEFINES_SVH
`define FIXED_STEP_BODY_INTEGRATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FSBI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSBI_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSBI_ASSERT(label, clk, rst_n, prop, msg)
`define FSBI_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: sv/fsbi_pkg.sv
// ----------------------------------------------------------------------------
// fsbi_pkg
// types and constants of the fixed step body integrator
// ----------------------------------------------------------------------------
`default_nettype none
package fsbi_pkg;
  localparam int unsigned MaxSubsteps = 8;
  localparam logic signed [31:0] DtQ16 = 32'sd1092;
  localparam logic signed [31:0] DampQ16 = 32'sd46959;
  localparam logic signed [31:0] GravityY = -32'sd102760448;
  localparam logic signed [15:0] NormalLimit = 16'sd29491;
  localparam logic [19:0] AccMax = 20'hFFFFF;

  typedef enum logic [3:0] {
    CMD_TICK = 4'd0, CMD_FORCE = 4'd1, CMD_IMPULSE = 4'd2, CMD_MANUAL = 4'd3,
    CMD_ACTUAL = 4'd4, CMD_BEGIN = 4'd5, CMD_OVERLAP = 4'd6, CMD_END = 4'd7,
    CMD_MOVE = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    REG_KINEMATIC = 2'd0, REG_EXTENT_X = 2'd1, REG_EXTENT_Y = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_CHECK, ST_S_VX, ST_S_VY, ST_S_DAMP, ST_S_PX, ST_S_PY,
    ST_P_CALC, ST_P_PICK, ST_OUT
  } state_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic [15:0]        elapsed_time;
    logic               other_is_ground;
    logic               own_is_particle;
    logic               flip_normal;
    logic signed [15:0] normal_y;
    logic [30:0]        obstacle_extent_x;
    logic [30:0]        obstacle_extent_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic               grounded;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// File: sv/fsbi_if.sv
// ----------------------------------------------------------------------------
// fsbi_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface fsbi_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/fixed_step_body_integrator_unit.sv
// ----------------------------------------------------------------------------
// fixed step body integrator unit
// 2d body state in q16.16 with fixed 1/60 s substeps and box push out
// ----------------------------------------------------------------------------
// usage:
//   in_if carries one command transaction (tick, force, impulse, velocity,
//   contact events, move); out_if returns one transaction per command with
//   position, velocity and grounded flag after that command.
//   configuration (kinematic, own extents) is written on cfg_we_i; the user
//   must write it only while idle, as the unit itself does not enforce this.
// sequence:
//   simple commands pass from the exec state to the output state; an overlap
//   with a ground partner also passes through the push out calc and pick
//   states. a tick runs n <= MAX_SUBSTEPS substeps, each one pass check plus
//   five passes through the shared 33x32 multiplier.
// flow:
//   one transaction is in flight at a time; in ready is low from acceptance
//   until the unit is back in idle after the result is taken.
// reset:
//   all body state, configuration and the accumulator clear to zero.
// stall:
//   the result is held on out_if until out ready is seen.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_step_body_integrator_unit_defines.svh"
module fixed_step_body_integrator_unit #(
  parameter int unsigned MAX_SUBSTEPS = fsbi_pkg::MaxSubsteps
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [30:0] cfg_data_i,
  fsbi_if.sink             in_if,
  fsbi_if.source           out_if
);
  import fsbi_pkg::*;

  localparam int unsigned StepW = $clog2(MAX_SUBSTEPS + 1);

  // body state
  logic signed [31:0] pos_x_q, pos_y_q, prev_x_q, prev_y_q;
  logic signed [31:0] vel_x_q, vel_y_q, man_x_q, man_y_q, acc_x_q, acc_y_q;
  logic [19:0] tacc_q;
  logic ground_q;
  logic kin_q;
  logic [30:0] ext_x_q, ext_y_q;

  state_e state_q, state_d;
  in_t item_q;
  logic [StepW-1:0] steps_q;
  out_t res;
  logic out_valid_q;

  // shared multiplier, registered product
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_k;
  logic signed [64:0] prod_q;
  logic signed [35:0] mq;   // rounded product, q16.16
  logic signed [64:0] rnd;

  // push out candidates
  logic signed [33:0] right_q, left_q, up_q, down_q;
  logic touch_q;

  logic signed [33:0] pminx, pmaxx, pminy, pmaxy, ominx, omaxx, ominy, omaxy;
  logic signed [33:0] best, mx, my;
  logic signed [33:0] ab, al, au, ad;
  logic signed [32:0] nf;
  logic n_up;

  assign rnd = prod_q + 65'sd32768;
  assign mq  = 36'(rnd >>> 16);   // arithmetic shift is floor, matches model

  // operand for the pass after the current one: y position before x position
  // so that the damped x velocity is settled before it is multiplied
  always_comb begin
    mul_a = 33'(acc_x_q);
    mul_k = DtQ16;
    unique case (state_q)
      ST_S_VX:   mul_a = 33'(acc_y_q);
      ST_S_VY:   begin mul_a = 33'(vel_x_q); mul_k = DampQ16; end
      ST_S_DAMP: mul_a = 33'(vel_y_q) + 33'(man_y_q);
      ST_S_PY:   mul_a = 33'(vel_x_q) + 33'(man_x_q);
      default:   mul_a = 33'(acc_x_q);
    endcase
  end

  always_comb begin
    pminx = 34'(pos_x_q) - 34'(ext_x_q);
    pmaxx = 34'(pos_x_q) + 34'(ext_x_q);
    pminy = 34'(pos_y_q) - 34'(ext_y_q);
    pmaxy = 34'(pos_y_q) + 34'(ext_y_q);
    ominx = 34'(item_q.value_x) - 34'(item_q.obstacle_extent_x);
    omaxx = 34'(item_q.value_x) + 34'(item_q.obstacle_extent_x);
    ominy = 34'(item_q.value_y) - 34'(item_q.obstacle_extent_y);
    omaxy = 34'(item_q.value_y) + 34'(item_q.obstacle_extent_y);
    ab = (right_q < 0) ? -right_q : right_q;
    al = (left_q < 0) ? -left_q : left_q;
    au = (up_q < 0) ? -up_q : up_q;
    ad = (down_q < 0) ? -down_q : down_q;
    best = ab; mx = right_q; my = '0;
    if (al < best) begin best = al; mx = left_q; my = '0; end
    if (au < best) begin best = au; mx = '0; my = up_q; end
    if (ad < best) begin mx = '0; my = down_q; end
    nf = item_q.flip_normal ? -33'(item_q.normal_y) : 33'(item_q.normal_y);
    n_up = nf > 33'(NormalLimit);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_if.valid) state_d = ST_EXEC;
      ST_EXEC: begin
        if (item_q.cmd == CMD_TICK && !kin_q) state_d = ST_CHECK;
        else if (item_q.cmd == CMD_OVERLAP && item_q.other_is_ground) state_d = ST_P_CALC;
        else state_d = ST_OUT;
      end
      ST_CHECK:  state_d = (tacc_q >= 20'(DtQ16) && 32'(steps_q) < MAX_SUBSTEPS)
                           ? ST_S_VX : ST_OUT;
      ST_S_VX:   state_d = ST_S_VY;
      ST_S_VY:   state_d = ST_S_DAMP;
      ST_S_DAMP: state_d = ST_S_PY;
      ST_S_PY:   state_d = ST_S_PX;
      ST_S_PX:   state_d = ST_CHECK;
      ST_P_CALC: state_d = ST_P_PICK;
      ST_P_PICK: state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // body state is frozen while the result waits
  always_comb begin
    res.position_x = pos_x_q;
    res.position_y = pos_y_q;
    res.velocity_x = vel_x_q;
    res.velocity_y = vel_y_q;
    res.grounded   = ground_q;
  end

  assign in_if.ready   = (state_q == ST_IDLE);
  assign out_if.valid  = out_valid_q;
  assign out_if.payload = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      kin_q <= 1'b0; ext_x_q <= '0; ext_y_q <= '0;
      pos_x_q <= '0; pos_y_q <= '0; prev_x_q <= '0; prev_y_q <= '0;
      vel_x_q <= '0; vel_y_q <= '0; man_x_q <= '0; man_y_q <= '0;
      acc_x_q <= '0; acc_y_q <= '0; tacc_q <= '0; ground_q <= 1'b0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_KINEMATIC: kin_q <= cfg_data_i[0];
          REG_EXTENT_X:  ext_x_q <= cfg_data_i;
          REG_EXTENT_Y:  ext_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_EXEC: begin
          steps_q <= '0;
          case (item_q.cmd)
            CMD_TICK: begin
              if (kin_q) begin
                vel_x_q <= sat32(36'(pos_x_q) - 36'(prev_x_q));
                vel_y_q <= sat32(36'(pos_y_q) - 36'(prev_y_q));
                prev_x_q <= pos_x_q; prev_y_q <= pos_y_q;
              end else begin
                tacc_q <= ({1'b0, tacc_q} + 21'(item_q.elapsed_time) > 21'(AccMax))
                          ? AccMax : tacc_q + 20'(item_q.elapsed_time);
              end
            end
            CMD_FORCE: begin
              acc_x_q <= sat32(36'(acc_x_q) + 36'(item_q.value_x));
              acc_y_q <= sat32(36'(acc_y_q) + 36'(item_q.value_y));
            end
            CMD_IMPULSE: begin
              vel_x_q <= sat32(36'(vel_x_q) + 36'(item_q.value_x));
              vel_y_q <= sat32(36'(vel_y_q) + 36'(item_q.value_y));
            end
            CMD_MANUAL: begin man_x_q <= item_q.value_x; man_y_q <= item_q.value_y; end
            CMD_ACTUAL: begin vel_x_q <= item_q.value_x; vel_y_q <= item_q.value_y; end
            CMD_BEGIN: begin
              if (item_q.other_is_ground && !item_q.own_is_particle) begin
                if (item_q.normal_y > NormalLimit) begin
                  ground_q <= 1'b1;
                  if (vel_y_q < 0) vel_y_q <= '0;
                end else if (item_q.normal_y < -NormalLimit) begin
                  if (vel_y_q > 0) vel_y_q <= '0;
                end
              end
            end
            CMD_OVERLAP: begin
              if (item_q.other_is_ground && !item_q.own_is_particle && n_up) begin
                ground_q <= 1'b1;
                if (vel_y_q < 0) vel_y_q <= '0;
              end
            end
            CMD_END: if (item_q.other_is_ground && !item_q.own_is_particle) ground_q <= 1'b0;
            CMD_MOVE: begin pos_x_q <= item_q.value_x; pos_y_q <= item_q.value_y; end
            default: ;
          endcase
        end
        ST_CHECK: begin
          // gravity folded into acc_y before it is multiplied, unless grounded
          if (tacc_q >= 20'(DtQ16) && 32'(steps_q) < MAX_SUBSTEPS && !ground_q)
            acc_y_q <= sat32(36'(acc_y_q) + 36'(GravityY));
        end
        ST_S_VX: vel_x_q <= sat32(36'(vel_x_q) + mq);
        ST_S_VY: vel_y_q <= sat32(36'(vel_y_q) + mq);
        ST_S_DAMP: if (ground_q) vel_x_q <= sat32(mq);
        ST_S_PY: pos_y_q <= sat32(36'(pos_y_q) + mq);
        ST_S_PX: begin
          pos_x_q <= sat32(36'(pos_x_q) + mq);
          acc_x_q <= '0; acc_y_q <= '0;
          tacc_q <= tacc_q - 20'(DtQ16);
          steps_q <= steps_q + 1'b1;
        end
        ST_P_PICK: if (touch_q) begin
          pos_x_q <= sat32(36'(pos_x_q) + 36'(mx));
          pos_y_q <= sat32(36'(pos_y_q) + 36'(my));
        end
        default: ;
      endcase
      if (state_q != ST_OUT && state_d == ST_OUT) out_valid_q <= 1'b1;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) item_q <= in_if.payload;
    prod_q <= 65'(mul_a) * 65'(mul_k);
    right_q <= omaxx - pminx;
    left_q  <= ominx - pmaxx;
    up_q    <= omaxy - pminy;
    down_q  <= ominy - pmaxy;
    touch_q <= pmaxx >= ominx && omaxx >= pminx && pmaxy >= ominy && omaxy >= pminy;
  end

  `FSBI_ASSERT(a_ready_idle, clk_i, rst_ni, out_valid_q |-> !in_if.ready, "ready while result pending")
  `FSBI_ASSERT(a_steps_max, clk_i, rst_ni, 32'(steps_q) <= MAX_SUBSTEPS, "too many substeps")
  `FSBI_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_q && !out_if.ready) |=> $stable(res), "result changed while stalled")
endmodule
`default_nettype wire

// File: tb/fixed_step_body_integrator_unit_tb.sv
// ----------------------------------------------------------------------------
// fixed step body integrator unit testbench
// drives command transactions with random gaps and output stalls, predicts
// the body state after every command and compares each returned transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fixed_step_body_integrator_unit_tb;
  import fsbi_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;

  fsbi_if #(.T(in_t))  in_if ();
  fsbi_if #(.T(out_t)) out_if ();

  fixed_step_body_integrator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  localparam int MAX_SUBSTEPS_TB = MaxSubsteps;

  // body model state
  logic signed [31:0] bx, by, prev_bx, prev_by, vx, vy, mvx, mvy, ax, ay;
  logic [19:0]        acc_time;
  logic               grounded_q;
  logic               kin_cfg;
  logic [30:0]        ext_x, ext_y;

  out_t   pending_state_q[$];
  int     errors = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round(a*k/65536), halves toward plus infinity
  function automatic longint fix_mul(input longint a, input longint k);
    longint t;
    t = a * k + 32768;
    if (t >= 0) return t / 65536;
    return -((-t + 65535) / 65536);
  endfunction

  function automatic longint absl(input longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic clear_body();
    bx = '0; by = '0; prev_bx = '0; prev_by = '0; vx = '0; vy = '0;
    mvx = '0; mvy = '0; ax = '0; ay = '0; acc_time = '0; grounded_q = 1'b0;
  endtask

  function automatic void run_substep();
    if (!grounded_q) ay = clamp32(longint'(ay) + longint'(GravityY));
    vx = clamp32(longint'(vx) + fix_mul(ax, DtQ16));
    vy = clamp32(longint'(vy) + fix_mul(ay, DtQ16));
    if (grounded_q) vx = clamp32(fix_mul(vx, DampQ16));
    bx = clamp32(longint'(bx) + fix_mul(longint'(vx) + longint'(mvx), DtQ16));
    by = clamp32(longint'(by) + fix_mul(longint'(vy) + longint'(mvy), DtQ16));
    ax = 0;
    ay = 0;
  endfunction

  function automatic void push_out(input in_t it);
    longint pminx, pmaxx, pminy, pmaxy, ominx, omaxx, ominy, omaxy;
    longint rgt, lft, upm, dnm, best, mx, my;
    pminx = longint'(bx) - ext_x; pmaxx = longint'(bx) + ext_x;
    pminy = longint'(by) - ext_y; pmaxy = longint'(by) + ext_y;
    ominx = longint'(it.value_x) - it.obstacle_extent_x;
    omaxx = longint'(it.value_x) + it.obstacle_extent_x;
    ominy = longint'(it.value_y) - it.obstacle_extent_y;
    omaxy = longint'(it.value_y) + it.obstacle_extent_y;
    if (!(pmaxx >= ominx && omaxx >= pminx && pmaxy >= ominy && omaxy >= pminy)) return;
    rgt = omaxx - pminx; lft = ominx - pmaxx; upm = omaxy - pminy; dnm = ominy - pmaxy;
    best = rgt; mx = rgt; my = 0;
    if (absl(lft) < absl(best)) begin best = lft; mx = lft; my = 0; end
    if (absl(upm) < absl(best)) begin best = upm; mx = 0; my = upm; end
    if (absl(dnm) < absl(best)) begin best = dnm; mx = 0; my = dnm; end
    bx = clamp32(longint'(bx) + mx);
    by = clamp32(longint'(by) + my);
  endfunction

  // advance the body model by one command, return state after it
  function automatic out_t body_after(input in_t it);
    out_t   r;
    int     steps;
    longint acc, ny;
    ny = it.normal_y;
    case (it.cmd)
      CMD_TICK: begin
        if (kin_cfg) begin
          vx = clamp32(longint'(bx) - longint'(prev_bx));
          vy = clamp32(longint'(by) - longint'(prev_by));
          prev_bx = bx; prev_by = by;
        end else begin
          acc = longint'(acc_time) + it.elapsed_time;
          if (acc > AccMax) acc = AccMax;
          steps = 0;
          while (acc >= DtQ16 && steps < MAX_SUBSTEPS_TB) begin
            run_substep();
            acc -= DtQ16;
            steps++;
          end
          acc_time = acc[19:0];
        end
      end
      CMD_FORCE: begin
        ax = clamp32(longint'(ax) + longint'(it.value_x));
        ay = clamp32(longint'(ay) + longint'(it.value_y));
      end
      CMD_IMPULSE: begin
        vx = clamp32(longint'(vx) + longint'(it.value_x));
        vy = clamp32(longint'(vy) + longint'(it.value_y));
      end
      CMD_MANUAL: begin mvx = it.value_x; mvy = it.value_y; end
      CMD_ACTUAL: begin vx = it.value_x; vy = it.value_y; end
      CMD_BEGIN: begin
        if (it.other_is_ground && !it.own_is_particle) begin
          if (ny > NormalLimit) begin
            grounded_q = 1'b1;
            if (vy < 0) vy = 0;
          end else if (ny < -longint'(NormalLimit)) begin
            if (vy > 0) vy = 0;
          end
        end
      end
      CMD_OVERLAP: begin
        if (it.other_is_ground) begin
          if (!it.own_is_particle) begin
            if ((it.flip_normal ? -ny : ny) > NormalLimit) begin
              grounded_q = 1'b1;
              if (vy < 0) vy = 0;
            end
          end
          push_out(it);
        end
      end
      CMD_END: if (it.other_is_ground && !it.own_is_particle) grounded_q = 1'b0;
      CMD_MOVE: begin bx = it.value_x; by = it.value_y; end
      default: ;
    endcase
    r.position_x = bx; r.position_y = by;
    r.velocity_x = vx; r.velocity_y = vy;
    r.grounded = grounded_q;
    return r;
  endfunction

  // config write while idle, mirrored in the model
  task automatic write_reg(input reg_e idx, input logic [30:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_KINEMATIC: kin_cfg = data[0];
      REG_EXTENT_X:  ext_x = data;
      default:       ext_y = data;
    endcase
  endtask

  task automatic drain();
    while (pending_state_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // one command transaction, with optional expected state typed in
  task automatic send_cmd(input in_t it, input bit has_typed, input out_t typed);
    out_t p;
    repeat ($urandom_range(0, 5)) @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.payload = it;
    do @(posedge clk_i); while (!in_if.ready);
    p = body_after(it);
    if (has_typed && p !== typed) begin
      errors++;
      if (errors <= 10) $display("model/table disagree: cmd %0d exp %h got %h", it.cmd, typed, p);
    end
    pending_state_q.push_back(p);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  function automatic in_t rand_item(input int mode);
    in_t it;
    it.cmd = cmd_e'($urandom_range(0, 8));
    if ($urandom_range(0, 40) == 0) it.cmd = 4'($urandom_range(9, 15));
    it.value_x = $urandom; it.value_y = $urandom;
    if (mode == 0 || $urandom_range(0, 3) != 0) begin
      // moderate magnitudes so the body stays in range
      it.value_x = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF;
      it.value_y = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF;
    end
    it.elapsed_time = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
    it.other_is_ground = $urandom_range(0, 4) != 0;
    it.own_is_particle = $urandom_range(0, 4) == 0;
    it.flip_normal = 1'($urandom);
    case ($urandom_range(0, 3))
      0: it.normal_y = 16'sd32767;
      1: it.normal_y = -16'sd32768;
      default: it.normal_y = 16'($urandom);
    endcase
    it.obstacle_extent_x = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
    it.obstacle_extent_y = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
    return it;
  endfunction

  // output side: random wait per transaction, compare with oldest expectation
  initial begin
    out_t        got, exp_s;
    int unsigned wait_n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_n = $urandom_range(0, 5);
      @(negedge clk_i);
      out_if.ready = 1'b0;
      repeat (wait_n) @(negedge clk_i);
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = out_if.payload;
      if (pending_state_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", got);
      end else begin
        exp_s = pending_state_q.pop_front();
        if (got.position_x !== exp_s.position_x || got.position_y !== exp_s.position_y ||
            got.velocity_x !== exp_s.velocity_x || got.velocity_y !== exp_s.velocity_y ||
            got.grounded !== exp_s.grounded) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp px %0d py %0d vx %0d vy %0d g %0b, got %0d %0d %0d %0d %0b",
                     exp_s.position_x, exp_s.position_y, exp_s.velocity_x, exp_s.velocity_y,
                     exp_s.grounded, got.position_x, got.position_y, got.velocity_x,
                     got.velocity_y, got.grounded);
        end
      end
    end
  end

  // directed table then random phases
  typedef struct {
    in_t  it;
    bit   typed;
    out_t res;
  } row_t;

  initial begin
    row_t  rows[$];
    row_t  rw;
    in_t   it;
    out_t  z;
    int    ph;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    kin_cfg = 1'b0; ext_x = '0; ext_y = '0;
    clear_body();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_reg(REG_EXTENT_X, 31'h0001_0000);
    write_reg(REG_EXTENT_Y, 31'h0001_0000);

    z = '0;
    // tick from reset with zero time: state stays zero
    rw.it = '0; rw.it.cmd = CMD_TICK; rw.typed = 1'b1; rw.res = z; rows.push_back(rw);
    // move to extremes
    rw.it = '0; rw.it.cmd = CMD_MOVE; rw.it.value_x = 32'sh7FFFFFFF;
    rw.it.value_y = 32'sh80000000; rw.typed = 1'b1; rw.res = z;
    rw.res.position_x = 32'sh7FFFFFFF; rw.res.position_y = 32'sh80000000; rows.push_back(rw);
    // impulse saturation
    rw.it = '0; rw.it.cmd = CMD_ACTUAL; rw.it.value_x = 32'sh7FFFFFFF;
    rw.it.value_y = 32'sh80000000; rw.typed = 1'b0; rows.push_back(rw);
    rw.it.cmd = CMD_IMPULSE; rows.push_back(rw);
    // full tick: largest elapsed time, all substeps
    rw.it = '0; rw.it.cmd = CMD_TICK; rw.it.elapsed_time = 16'hFFFF; rows.push_back(rw);
    rw.it.cmd = CMD_MOVE; rows.push_back(rw);
    rw.it = '0; rw.it.cmd = CMD_ACTUAL; rows.push_back(rw);
    rw.it.cmd = CMD_FORCE; rw.it.value_x = 32'sh0010_0000; rw.it.value_y = -32'sh0010_0000;
    rows.push_back(rw);
    rw.it.cmd = CMD_MANUAL; rows.push_back(rw);
    rw.it = '0; rw.it.cmd = CMD_TICK; rw.it.elapsed_time = 16'd1092; rows.push_back(rw);
    // begin contact: up, down, particle, not ground, threshold edge
    rw.it = '0; rw.it.cmd = CMD_BEGIN; rw.it.other_is_ground = 1'b1;
    rw.it.normal_y = -16'sd32768; rows.push_back(rw);
    rw.it.normal_y = 16'sd29491; rows.push_back(rw);
    rw.it.own_is_particle = 1'b1; rw.it.normal_y = 16'sd32767; rows.push_back(rw);
    rw.it.own_is_particle = 1'b0; rw.it.other_is_ground = 1'b0; rows.push_back(rw);
    rw.it.other_is_ground = 1'b1; rw.it.normal_y = 16'sd29492; rows.push_back(rw);
    rw.it = '0; rw.it.cmd = CMD_TICK; rw.it.elapsed_time = 16'd5000; rows.push_back(rw);
    // overlap: flipped normal, push out, particle push, no touch
    rw.it = '0; rw.it.cmd = CMD_OVERLAP; rw.it.other_is_ground = 1'b1;
    rw.it.flip_normal = 1'b1;
    rw.it.normal_y = -16'sd32768; rw.it.obstacle_extent_x = 31'h0002_0000;
    rw.it.obstacle_extent_y = 31'h0000_8000; rows.push_back(rw);
    rw.it.own_is_particle = 1'b1; rw.it.value_x = 32'sh0001_0000; rows.push_back(rw);
    rw.it.value_x = 32'sh4000_0000; rows.push_back(rw);
    rw.it.obstacle_extent_x = 31'h7FFFFFFF; rw.it.obstacle_extent_y = 31'h7FFFFFFF;
    rw.it.own_is_particle = 1'b0; rows.push_back(rw);
    // end contact, unused code
    rw.it = '0; rw.it.cmd = CMD_END; rw.it.other_is_ground = 1'b1; rows.push_back(rw);
    rw.it.cmd = 4'd15; rw.it.value_x = -1; rows.push_back(rw);
    foreach (rows[i]) send_cmd(rows[i].it, rows[i].typed, rows[i].res);

    // sender pauses until every result is back
    drain();
    // kinematic phase
    write_reg(REG_KINEMATIC, 31'd1);
    write_reg(REG_EXTENT_X, 31'h7FFFFFFF);
    for (int k = 0; k < 100; k++) send_cmd(rand_item(1), 0, z);
    drain();
    write_reg(REG_KINEMATIC, 31'd0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(REG_EXTENT_X, 31'd0); write_reg(REG_EXTENT_Y, 31'd0); end
        1: begin write_reg(REG_EXTENT_X, 31'h0004_0000); write_reg(REG_EXTENT_Y, 31'h7FFFFFFF); end
        2: begin write_reg(REG_EXTENT_X, 31'($urandom)); write_reg(REG_EXTENT_Y, 31'h0002_0000); end
        default: begin write_reg(REG_EXTENT_X, 31'h0010_0000); write_reg(REG_EXTENT_Y, 31'h0010_0000); end
      endcase
      for (int k = 0; k < 400; k++) begin
        it = rand_item(ph == 3 ? 0 : 1);
        send_cmd(it, 0, z);
      end
      drain();
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
